/* hdl/btn_dbnc_pkg.sv */
// ---------------------------------------------------------------------------
// btn_dbnc_pkg: button debounce and long-press shared definitions
// Widths, register indexes, reset values and the debounce state type used by the
// button debounce and long-press unit.
// ---------------------------------------------------------------------------
package btn_dbnc_pkg;

   // payload widths
   localparam int TIME_W      = 32;
   localparam int CFG_TIME_W  = 16;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE_TIME   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LONG_PRESS_TIME = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ACTIVE_LOW      = 2'd2;

   // configuration reset values
   localparam logic [CFG_TIME_W-1:0] DEBOUNCE_TIME_RST   = 16'd50;
   localparam logic [CFG_TIME_W-1:0] LONG_PRESS_TIME_RST = 16'd1000;
   localparam logic                  ACTIVE_LOW_RST      = 1'b1;

   // debounce state machine
   typedef enum logic [1:0] {
      ST_RELEASED    = 2'd0,
      ST_DEB_PRESS   = 2'd1,
      ST_PRESSED     = 2'd2,
      ST_DEB_RELEASE = 2'd3
   } fsm_state_type;

endpackage

/* hdl/button_debounce_long_press_unit.sv */
// ---------------------------------------------------------------------------
// button_debounce_long_press_unit: debounced button with long-press event
// Turns timestamped raw pin samples into press, release and long-press
// event pulses plus a held flag, one result per sample.
// ---------------------------------------------------------------------------
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------
//  req      | in        | req_tvalid/req_tready | raw_level, now_ms
//  rsp      | out       | rsp_tvalid/rsp_tready | press/release/long events, held
//  csr      | in        | csr_valid/csr_ready   | csr_index, csr_data
//
//  One sample per clock sustained while rsp is not stalled; a sample passes
//  through the input register, then its result loads the result register.
//  The state step (two 32-bit wrapping subtracts and compares) sits between them.
//  Reset is synchronous and returns the state to released and the
//  configuration to 50 ms debounce, 1000 ms long press, active low.
//  A stalled rsp holds its result; one more sample waits in the input
//  register, after which req_tready drops.
//  csr writes are always taken.
module button_debounce_long_press_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: [0] raw_level, [32:1] now_ms, [39:33] zero
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [btn_dbnc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // rsp_tdata: [0] press_event, [1] release_event, [2] long_press_event,
   //            [3] held, [7:4] zero
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [btn_dbnc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [btn_dbnc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [btn_dbnc_pkg::CSR_DATA_W-1:0]   csr_data
);

   // configuration registers
   logic [btn_dbnc_pkg::CFG_TIME_W-1:0] debounce_time_ff;
   logic [btn_dbnc_pkg::CFG_TIME_W-1:0] long_press_time_ff;
   logic                                active_low_ff;

   // input register
   logic                              in_valid_ff;
   logic                              in_level_ff;
   logic [btn_dbnc_pkg::TIME_W-1:0]   in_now_ff;

   // debounce state
   btn_dbnc_pkg::fsm_state_type       state_ff, state_in;
   logic [btn_dbnc_pkg::TIME_W-1:0]   phase_start_ff, phase_start_in;
   logic [btn_dbnc_pkg::TIME_W-1:0]   press_start_ff, press_start_in;
   logic                              long_done_ff, long_done_in;

   // result register
   logic                              rsp_valid_ff;
   logic                              press_ev_ff, press_ev_in;
   logic                              release_ev_ff, release_ev_in;
   logic                              long_ev_ff, long_ev_in;
   logic                              held_ff, held_in;

   logic                              advance;
   logic                              pressed;
   logic                              debounce_done;
   logic                              long_due;
   logic [btn_dbnc_pkg::TIME_W-1:0]   phase_age;
   logic [btn_dbnc_pkg::TIME_W-1:0]   press_age;

   // handshakes
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_time_ff   <= btn_dbnc_pkg::DEBOUNCE_TIME_RST;
         long_press_time_ff <= btn_dbnc_pkg::LONG_PRESS_TIME_RST;
         active_low_ff      <= btn_dbnc_pkg::ACTIVE_LOW_RST;
      end else if (csr_valid) begin
         case (csr_index)
            btn_dbnc_pkg::REG_DEBOUNCE_TIME:   debounce_time_ff   <= csr_data;
            btn_dbnc_pkg::REG_LONG_PRESS_TIME: long_press_time_ff <= csr_data;
            btn_dbnc_pkg::REG_ACTIVE_LOW:      active_low_ff      <= csr_data[0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_level_ff <= req_tdata[0];
         in_now_ff   <= req_tdata[btn_dbnc_pkg::TIME_W:1];
      end
   end

   // wrapping elapsed-time tests
   assign pressed       = in_level_ff ^ active_low_ff;
   assign phase_age     = in_now_ff - phase_start_ff;
   assign press_age     = in_now_ff - press_start_ff;
   assign debounce_done = phase_age >= {16'd0, debounce_time_ff};
   assign long_due      = press_age >= {16'd0, long_press_time_ff};

   // next state and event pulses
   always_comb begin
      state_in       = state_ff;
      phase_start_in = phase_start_ff;
      press_start_in = press_start_ff;
      long_done_in   = long_done_ff;
      press_ev_in    = 1'b0;
      release_ev_in  = 1'b0;
      long_ev_in     = 1'b0;
      if (advance) begin
         case (state_ff)
            btn_dbnc_pkg::ST_RELEASED: begin
               if (pressed) begin
                  phase_start_in = in_now_ff;
                  state_in       = btn_dbnc_pkg::ST_DEB_PRESS;
               end
            end
            btn_dbnc_pkg::ST_DEB_PRESS: begin
               if (!pressed) begin
                  state_in = btn_dbnc_pkg::ST_RELEASED;
               end else if (debounce_done) begin
                  state_in       = btn_dbnc_pkg::ST_PRESSED;
                  press_start_in = in_now_ff;
                  long_done_in   = 1'b0;
                  press_ev_in    = 1'b1;
               end
            end
            btn_dbnc_pkg::ST_PRESSED: begin
               // long-press test comes before the release test
               if (!long_done_ff && long_due) begin
                  long_ev_in   = 1'b1;
                  long_done_in = 1'b1;
               end
               if (!pressed) begin
                  phase_start_in = in_now_ff;
                  state_in       = btn_dbnc_pkg::ST_DEB_RELEASE;
               end
            end
            btn_dbnc_pkg::ST_DEB_RELEASE: begin
               // bounce back keeps press_start and long_done
               if (pressed) begin
                  state_in = btn_dbnc_pkg::ST_PRESSED;
               end else if (debounce_done) begin
                  state_in      = btn_dbnc_pkg::ST_RELEASED;
                  release_ev_in = 1'b1;
               end
            end
            default: state_in = btn_dbnc_pkg::ST_RELEASED;
         endcase
      end
      held_in = (state_in == btn_dbnc_pkg::ST_PRESSED) ||
                (state_in == btn_dbnc_pkg::ST_DEB_RELEASE);
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= btn_dbnc_pkg::ST_RELEASED;
         phase_start_ff <= '0;
         press_start_ff <= '0;
         long_done_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_start_ff <= phase_start_in;
         press_start_ff <= press_start_in;
         long_done_ff   <= long_done_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         press_ev_ff   <= press_ev_in;
         release_ev_ff <= release_ev_in;
         long_ev_ff    <= long_ev_in;
         held_ff       <= held_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, held_ff, long_ev_ff, release_ev_ff, press_ev_ff};

   // checks
   a_press_release_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(press_ev_ff && release_ev_ff))
      else $error("press and release event in one result");

   a_press_means_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && press_ev_ff) |-> held_ff)
      else $error("press event without held");

   a_release_means_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && release_ev_ff) |-> !held_ff)
      else $error("release event while still held");

   a_stall_only_on_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_valid_ff && !rsp_tready && in_valid_ff))
      else $error("input stalled without a blocked result");

   a_long_done_with_event: assert property (@(posedge clock) disable iff (reset)
      $rose(long_done_ff) |-> (rsp_valid_ff && long_ev_ff))
      else $error("long press marked done without an event");

endmodule
